// File: src/ssp_pkg.sv
// Shared types and constants for the sprite screen projection block.
package ssp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int DIM_W         = 13;
    localparam int DIM_MAX       = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_POS_X     = 3'd0,
        REG_CAM_POS_Y     = 3'd1,
        REG_CAM_DIR_X     = 3'd2,
        REG_CAM_DIR_Y     = 3'd3,
        REG_CAM_PLANE_X   = 3'd4,
        REG_CAM_PLANE_Y   = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
    } cam_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } scr_t;

endpackage

// File: src/ssp_div_pipe.sv
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module ssp_div_pipe #(
    parameter int DW = 64,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [1:0][DW-1:0]  in_rem,
    input  logic [1:0][QW-1:0]  in_low,
    input  logic [DW-1:0]       in_div,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [1:0][QW-1:0]  out_quo,
    output logic [SW-1:0]       out_side
);

    // The partial remainder stays below the divisor only when the first remainder does, and then fits DW bits.
    logic               vld_reg  [QW];
    logic [1:0][DW-1:0] rem_reg  [QW];
    logic [1:0][QW-1:0] low_reg  [QW];
    logic [1:0][QW-1:0] quo_reg  [QW];
    logic [DW-1:0]      div_reg  [QW];
    logic [SW-1:0]      side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic               vld_in;
        logic [1:0][DW-1:0] rem_in;
        logic [1:0][QW-1:0] low_in;
        logic [1:0][QW-1:0] quo_in;
        logic [DW-1:0]      div_in;
        logic [SW-1:0]      side_in;
        logic [1:0][DW-1:0] rem_next;
        logic [1:0][QW-1:0] low_next;
        logic [1:0][QW-1:0] quo_next;

        if (i == 0) begin : g_head
            assign vld_in  = in_valid;
            assign rem_in  = in_rem;
            assign low_in  = in_low;
            assign quo_in  = '0;
            assign div_in  = in_div;
            assign side_in = in_side;
        end else begin : g_tail
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign low_in  = low_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign div_in  = div_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DW:0] trial;
            logic [DW:0] diff;
            assign trial       = {rem_in[l], low_in[l][QW-1]};
            assign diff        = trial - {1'b0, div_in};
            assign rem_next[l] = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            assign low_next[l] = {low_in[l][QW-2:0], 1'b0};
            assign quo_next[l] = {quo_in[l][QW-2:0], ~diff[DW]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= low_next;
                quo_reg[i]  <= quo_next;
                div_reg[i]  <= div_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// File: src/ssp_xform.sv
// Camera-space transform: offsets, products, differences and the two divisions by the determinant.
module ssp_xform #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [31:0] sprite_pos_x,
    input  logic signed [31:0] sprite_pos_y,
    input  ssp_pkg::cam_t      cam,
    output logic               out_valid,
    output logic signed [31:0] tx,
    output logic signed [31:0] ty
);
    import ssp_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] mag65(input logic signed [64:0] v);
        logic [64:0] n;
        n = v[64] ? (~v + 65'd1) : v;
        return n[63:0];
    endfunction

    // A quotient that overflowed saturates toward the sign of the result.
    function automatic logic signed [31:0] finish(input logic [31:0] q, input logic ov,
                                                 input logic neg);
        if (neg) begin
            if (ov || q > 32'h8000_0000) begin
                return 32'sh8000_0000;
            end
            return ~q + 32'd1;
        end
        if (ov || q[31]) begin
            return 32'sh7fff_ffff;
        end
        return q;
    endfunction

    // Stage 1: saturated offsets.
    logic               vld1_reg;
    logic signed [31:0] dx_reg, dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= sat32(33'(sprite_pos_x) - 33'(cam.pos_x));
            dy_reg <= sat32(33'(sprite_pos_y) - 33'(cam.pos_y));
        end
    end

    // Stage 2: six products.
    logic               vld2_reg;
    logic signed [63:0] pdet_a_reg, pdet_b_reg, pnx_a_reg, pnx_b_reg, pny_a_reg, pny_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pdet_a_reg <= cam.plane_x * cam.dir_y;
            pdet_b_reg <= cam.dir_x * cam.plane_y;
            pnx_a_reg  <= cam.dir_y * dx_reg;
            pnx_b_reg  <= cam.dir_x * dy_reg;
            pny_a_reg  <= cam.plane_x * dy_reg;
            pny_b_reg  <= cam.plane_y * dx_reg;
        end
    end

    // Stage 3: exact differences.
    logic               vld3_reg;
    logic signed [64:0] det_reg, nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= 65'(pdet_a_reg) - 65'(pdet_b_reg);
            nx_reg  <= 65'(pnx_a_reg) - 65'(pnx_b_reg);
            ny_reg  <= 65'(pny_a_reg) - 65'(pny_b_reg);
        end
    end

    // Stage 4: sign and magnitude.
    logic        vld4_reg;
    logic [63:0] det_mag_reg, nx_mag_reg, ny_mag_reg;
    logic        det_neg_reg, nx_neg_reg, ny_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_mag_reg <= mag65(det_reg);
            nx_mag_reg  <= mag65(nx_reg);
            ny_mag_reg  <= mag65(ny_reg);
            det_neg_reg <= det_reg[64];
            nx_neg_reg  <= nx_reg[64];
            ny_neg_reg  <= ny_reg[64];
        end
    end

    // Stage 5: the dividend is mag << FRAC_BITS; its bits from bit 32 up form the first remainder.
    logic [63:0]           nx_hi, ny_hi;
    logic [63+FRAC_BITS:0] nx_sh, ny_sh;
    logic                  vld5_reg;
    logic [1:0][63:0]      rem0_reg;
    logic [1:0][31:0]      low0_reg;
    logic [63:0]           div0_reg;
    logic [4:0]            side5_reg;

    assign nx_hi = nx_mag_reg >> (32 - FRAC_BITS);
    assign ny_hi = ny_mag_reg >> (32 - FRAC_BITS);
    assign nx_sh = {nx_mag_reg, {FRAC_BITS{1'b0}}};
    assign ny_sh = {ny_mag_reg, {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (adv) begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem0_reg[0] <= nx_hi;
            rem0_reg[1] <= ny_hi;
            low0_reg[0] <= nx_sh[31:0];
            low0_reg[1] <= ny_sh[31:0];
            div0_reg    <= det_mag_reg;
            side5_reg   <= {nx_hi >= det_mag_reg, ny_hi >= det_mag_reg,
                            nx_neg_reg ^ det_neg_reg, ny_neg_reg ^ det_neg_reg,
                            det_mag_reg == 64'd0};
        end
    end

    logic             dv_valid;
    logic [1:0][31:0] dv_quo;
    logic [4:0]       dv_side;

    ssp_div_pipe #(
        .DW (64),
        .QW (32),
        .SW (5)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld5_reg),
        .in_rem    (rem0_reg),
        .in_low    (low0_reg),
        .in_div    (div0_reg),
        .in_side   (side5_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Final stage: saturate, apply sign; a zero determinant gives zero transforms.
    logic               vld6_reg;
    logic signed [31:0] tx_reg, ty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld6_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg <= dv_side[0] ? 32'sd0 : finish(dv_quo[0], dv_side[4], dv_side[2]);
            ty_reg <= dv_side[0] ? 32'sd0 : finish(dv_quo[1], dv_side[3], dv_side[1]);
        end
    end

    assign out_valid = vld6_reg;
    assign tx        = tx_reg;
    assign ty        = ty_reg;

endmodule

// File: src/ssp_screen.sv
// Screen projection: column and size divisions by depth, then row and column clipping.
module ssp_screen #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [31:0] tx,
    input  logic signed [31:0] ty,
    input  ssp_pkg::scr_t      scr,
    output logic               out_valid,
    output logic signed [16:0] screen_col,
    output logic [15:0]        sprite_size,
    output logic [11:0]        row_start,
    output logic [11:0]        row_end,
    output logic [15:0]        col_start,
    output logic signed [16:0] col_end,
    output logic signed [31:0] cam_depth,
    output logic               behind_camera
);
    import ssp_pkg::*;

    localparam int QB   = 17;
    localparam int SN_W = DIM_W + FRAC_BITS;
    localparam int CW   = (SN_W > 32) ? SN_W : 32;

    // Stage 1: ty + tx and the behind test.
    logic               vld1_reg, beh1_reg;
    logic signed [32:0] sum_reg;
    logic signed [31:0] ty1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg  <= 33'(ty) + 33'(tx);
            ty1_reg  <= ty;
            beh1_reg <= ty[31] || (ty == 32'sd0);
        end
    end

    // Stage 2: (width / 2) * (ty + tx).
    logic               vld2_reg, beh2_reg;
    logic signed [45:0] prod_reg;
    logic signed [31:0] ty2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= $signed({1'b0, scr.width[DIM_W-1:1]}) * sum_reg;
            ty2_reg  <= ty1_reg;
            beh2_reg <= beh1_reg;
        end
    end

    // Stage 3: magnitude of the column numerator.
    logic               vld3_reg, beh3_reg, cneg3_reg;
    logic [45:0]        cmag_reg;
    logic signed [31:0] ty3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmag_reg  <= prod_reg[45] ? (~prod_reg + 46'd1) : prod_reg;
            cneg3_reg <= prod_reg[45];
            ty3_reg   <= ty2_reg;
            beh3_reg  <= beh2_reg;
        end
    end

    // Stage 4: overflow tests and divider set-up; both lanes divide by the depth.
    logic [31:0]     dvs;
    logic [45:0]     chi;
    logic [SN_W-1:0] snum, shi;

    assign dvs  = beh3_reg ? 32'd1 : ty3_reg;
    assign chi  = cmag_reg >> QB;
    assign snum = {scr.height, {FRAC_BITS{1'b0}}};
    assign shi  = snum >> QB;

    logic             vld4_reg;
    logic [1:0][31:0] rem0_reg;
    logic [1:0][16:0] low0_reg;
    logic [31:0]      div0_reg;
    logic [35:0]      side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem0_reg[0] <= chi[31:0];
            rem0_reg[1] <= 32'(shi);
            low0_reg[0] <= cmag_reg[QB-1:0];
            low0_reg[1] <= snum[QB-1:0];
            div0_reg    <= dvs;
            side4_reg   <= {ty3_reg, beh3_reg, cneg3_reg, chi >= 46'(dvs),
                            CW'(shi) >= CW'(dvs)};
        end
    end

    logic             dv_valid;
    logic [1:0][16:0] dv_quo;
    logic [35:0]      dv_side;

    ssp_div_pipe #(
        .DW (32),
        .QW (QB),
        .SW (36)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vld4_reg),
        .in_rem    (rem0_reg),
        .in_low    (low0_reg),
        .in_div    (div0_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Stage 5: saturate column and size.
    logic        d_beh, d_cneg, d_cov, d_sov;
    logic [16:0] colmag;
    logic [16:0] col_next;
    logic [15:0] size_next;

    assign {d_beh, d_cneg, d_cov, d_sov} = dv_side[3:0];

    always_comb begin
        colmag = (d_cov || dv_quo[0] > 17'd65536) ? 17'd65536 : dv_quo[0];
        if (d_beh) begin
            col_next = '0;
        end else if (d_cneg) begin
            col_next = ~colmag + 17'd1;
        end else begin
            col_next = (d_cov || dv_quo[0][16]) ? 17'h0ffff : dv_quo[0];
        end
        if (d_beh) begin
            size_next = '0;
        end else begin
            size_next = (d_sov || dv_quo[1][16]) ? 16'hffff : dv_quo[1][15:0];
        end
    end

    logic               vld5_reg, beh5_reg;
    logic signed [16:0] col5_reg;
    logic [15:0]        size5_reg;
    logic signed [31:0] ty5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (adv) begin
            vld5_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            col5_reg  <= col_next;
            size5_reg <= size_next;
            ty5_reg   <= dv_side[35:4];
            beh5_reg  <= d_beh;
        end
    end

    // Stage 6: spans around the screen center and the sprite column, clipped to the screen.
    logic [15:0]        half16, hh16, re_full;
    logic signed [17:0] cs_full, ce_full;
    logic [11:0]        rs_next, re_next;
    logic [15:0]        cs_next;
    logic [16:0]        ce_next;

    always_comb begin
        half16  = {1'b0, size5_reg[15:1]};
        hh16    = 16'(scr.height[DIM_W-1:1]);
        re_full = hh16 + half16;
        cs_full = {col5_reg[16], col5_reg} - $signed({3'b000, half16[14:0]});
        ce_full = {col5_reg[16], col5_reg} + $signed({3'b000, half16[14:0]});
        rs_next = (hh16 >= half16) ? 12'(hh16 - half16) : 12'd0;
        re_next = (re_full >= 16'(scr.height)) ? 12'(scr.height - 13'd1) : 12'(re_full);
        cs_next = cs_full[17] ? 16'd0 : cs_full[15:0];
        ce_next = (ce_full >= $signed(18'(scr.width))) ? 17'(scr.width - 13'd1)
                                                        : ce_full[16:0];
        if (beh5_reg) begin
            rs_next = '0;
            re_next = '0;
            cs_next = '0;
            ce_next = '0;
        end
    end

    logic               vld6_reg, beh6_reg;
    logic signed [16:0] col6_reg, ce6_reg;
    logic [15:0]        size6_reg, cs6_reg;
    logic [11:0]        rs6_reg, re6_reg;
    logic signed [31:0] ty6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            col6_reg  <= col5_reg;
            size6_reg <= size5_reg;
            rs6_reg   <= rs_next;
            re6_reg   <= re_next;
            cs6_reg   <= cs_next;
            ce6_reg   <= ce_next;
            ty6_reg   <= ty5_reg;
            beh6_reg  <= beh5_reg;
        end
    end

    assign out_valid     = vld6_reg;
    assign screen_col    = col6_reg;
    assign sprite_size   = size6_reg;
    assign row_start     = rs6_reg;
    assign row_end       = re6_reg;
    assign col_start     = cs6_reg;
    assign col_end       = ce6_reg;
    assign cam_depth     = ty6_reg;
    assign behind_camera = beh6_reg;

endmodule

// File: src/sprite_screen_projection.sv
// Top level of the sprite screen projection block: camera registers and the pipeline.
//
//  Channel  Direction  Handshake            Word
//  s_       in         s_valid / s_ready    sprite_pos_x, sprite_pos_y
//  m_       out        m_valid / m_ready    col, size, row/col spans, depth, behind
//  cfg_     in         cfg_wr_en            cfg_index, cfg_data
//
// One word enters per cycle while s_ready is high.
// The pipeline holds the 32-stage determinant divider and the 17-stage depth divider.
// Reset is synchronous and active low; it clears valid bits and loads the camera and screen defaults.
// When the output word is not taken, the whole pipeline holds and s_ready drops.
module sprite_screen_projection #(
    parameter int FRAC_BITS = ssp_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_sprite_pos_x,
    input  logic signed [31:0]            s_sprite_pos_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [16:0]            m_screen_col,
    output logic [15:0]                   m_sprite_size,
    output logic [11:0]                   m_row_start,
    output logic [11:0]                   m_row_end,
    output logic [15:0]                   m_col_start,
    output logic signed [16:0]            m_col_end,
    output logic signed [31:0]            m_cam_depth,
    output logic                          m_behind_camera,
    input  logic                          cfg_wr_en,
    input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssp_pkg::*;

    localparam logic [31:0] DIR_X_RST   = 32'd1 << FRAC_BITS;
    localparam logic [63:0] PLANE_Y_W   = (64'd43254 << FRAC_BITS) >> 16;
    localparam logic [31:0] PLANE_Y_RST = PLANE_Y_W[31:0];

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (v > DIM_W'(DIM_MAX)) begin
            return DIM_W'(DIM_MAX);
        end
        return v;
    endfunction

    cam_t             cam_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    scr_t             scr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg.pos_x   <= '0;
            cam_reg.pos_y   <= '0;
            cam_reg.dir_x   <= DIR_X_RST;
            cam_reg.dir_y   <= '0;
            cam_reg.plane_x <= '0;
            cam_reg.plane_y <= PLANE_Y_RST;
            width_reg       <= DIM_W'(640);
            height_reg      <= DIM_W'(480);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CAM_POS_X:     cam_reg.pos_x   <= cfg_data;
                REG_CAM_POS_Y:     cam_reg.pos_y   <= cfg_data;
                REG_CAM_DIR_X:     cam_reg.dir_x   <= cfg_data;
                REG_CAM_DIR_Y:     cam_reg.dir_y   <= cfg_data;
                REG_CAM_PLANE_X:   cam_reg.plane_x <= cfg_data;
                REG_CAM_PLANE_Y:   cam_reg.plane_y <= cfg_data;
                REG_SCREEN_WIDTH:  width_reg       <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_reg      <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign scr.width  = clamp_dim(width_reg);
    assign scr.height = clamp_dim(height_reg);

    // All stages advance together whenever the output register is free or being emptied.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic               xf_valid;
    logic signed [31:0] xf_tx, xf_ty;

    ssp_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_valid),
        .sprite_pos_x (s_sprite_pos_x),
        .sprite_pos_y (s_sprite_pos_y),
        .cam          (cam_reg),
        .out_valid    (xf_valid),
        .tx           (xf_tx),
        .ty           (xf_ty)
    );

    ssp_screen #(
        .FRAC_BITS (FRAC_BITS)
    ) u_screen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (xf_valid),
        .tx            (xf_tx),
        .ty            (xf_ty),
        .scr           (scr),
        .out_valid     (m_valid),
        .screen_col    (m_screen_col),
        .sprite_size   (m_sprite_size),
        .row_start     (m_row_start),
        .row_end       (m_row_end),
        .col_start     (m_col_start),
        .col_end       (m_col_end),
        .cam_depth     (m_cam_depth),
        .behind_camera (m_behind_camera)
    );

    a_behind_matches_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_behind_camera == (m_cam_depth <= 32'sd0)))
        else $error("behind flag disagrees with depth");

    a_behind_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_behind_camera |->
            m_sprite_size == '0 && m_screen_col == '0 && m_col_end == '0 &&
            m_row_end == '0)
        else $error("sprite behind camera has nonzero span");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_behind_camera |-> m_row_start <= m_row_end)
        else $error("row span inverted");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline is stalled");

endmodule
